>>> rtl/sdac_pkg.sv
`default_nettype none

package sdac_pkg;

  // field widths
  localparam int OP_BITS       = 2;
  localparam int FREQ_BITS     = 28;
  localparam int ADC_BITS      = 12;
  localparam int GEN_WORD_BITS = 16;
  localparam int CMD_BITS      = 4;
  localparam int HALF_BITS     = 8;
  localparam int COUNT_BITS    = 5;

  // operation codes carried in tuser
  localparam logic [OP_BITS-1:0] OP_TICK = 2'd0;
  localparam logic [OP_BITS-1:0] OP_FREQ = 2'd1;
  localparam logic [OP_BITS-1:0] OP_READ = 2'd2;

  // generator words
  localparam logic [GEN_WORD_BITS-1:0] GEN_CTRL_WORD = 16'h2100;
  localparam logic [GEN_WORD_BITS-1:0] GEN_FREQ_FLAG = 16'h4000;
  localparam int                       FREQ_HALF     = 14;

  // converter command: start, single-ended, channel, msb first
  localparam logic [CMD_BITS-1:0] ADC_CMD_BASE = 4'hD;

  localparam logic [HALF_BITS-1:0] HALF_RESET = 8'd5;

  // register map
  localparam logic [0:0] REG_HALF_PERIOD = 1'b0;

  // word k of a frequency load
  function automatic logic [GEN_WORD_BITS-1:0] gen_word(input logic [1:0] k,
                                                       input logic [FREQ_BITS-1:0] freq);
    logic [GEN_WORD_BITS-1:0] w;
    begin
      if (k == 2'd0) begin
        w = GEN_CTRL_WORD;
      end else if (k == 2'd1) begin
        w = {2'b00, freq[FREQ_HALF-1:0]} | GEN_FREQ_FLAG;
      end else begin
        w = {2'b00, freq[FREQ_BITS-1:FREQ_HALF]} | GEN_FREQ_FLAG;
      end
      return w;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/spi_dds_adc_controller.sv
`default_nettype none

// Serial master for a signal generator and a two-channel 12-bit converter. Each
// input word is a tick (tuser 0), a start command (1 frequency load, 2 converter
// read) or a no-op (3). A frequency load shifts out three 16-bit words MSB first
// under gen_select_n; a read sends four command bits under adc_select_n and then
// clocks in 12 data bits from miso. Every word yields one result word holding the
// line levels, the last sample and status flags. The block takes one word per
// clock while the result register is empty or being taken: a single registered
// pass updates the sequencer state and loads the output register, and a new word
// is taken while the previous result waits as long as the output side is ready.
// The serial clock runs at half_period_ticks tick words per half period (0 as 1).
module spi_dds_adc_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  // apb configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tune_word[27:0], channel[28], miso[29], zero fill[31:30]
  input  wire logic [31:0] s_axis_tdata,
  // op[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // sclk[0], mosi[1], gen_select_n[2], adc_select_n[3], sample[15:4],
  // sample_valid[16], busy_res[17], rejected[18], zero fill[23:19]
  output logic      [23:0] m_axis_tdata
);

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_GEN  = 4'd1;
  localparam logic [3:0] PH_GAP  = 4'd2;
  localparam logic [3:0] PH_CMD  = 4'd3;
  localparam logic [3:0] PH_DATA = 4'd4;

  logic [sdac_pkg::HALF_BITS-1:0]     half_period_ticks;
  logic [3:0]                         phase, phase_next;
  logic [sdac_pkg::COUNT_BITS-1:0]    bit_count, bit_count_next;
  logic [1:0]                         word_index, word_index_next;
  logic [sdac_pkg::GEN_WORD_BITS-1:0] shift_out, shift_out_next;
  logic [sdac_pkg::ADC_BITS-1:0]      shift_in, shift_in_next;
  logic [sdac_pkg::HALF_BITS-1:0]     divider, divider_next;
  logic [sdac_pkg::FREQ_BITS-1:0]     held_freq, held_freq_next;
  logic                               held_channel, held_channel_next;
  logic                               sclk, sclk_next;
  logic                               mosi, mosi_next;
  logic                               gen_sel_n, gen_sel_n_next;
  logic                               adc_sel_n, adc_sel_n_next;
  logic [sdac_pkg::ADC_BITS-1:0]      last_sample, last_sample_next;

  logic                               accept;
  logic [sdac_pkg::OP_BITS-1:0]       in_op;
  logic [sdac_pkg::FREQ_BITS-1:0]     in_freq;
  logic                               in_channel;
  logic                               in_miso;
  logic [sdac_pkg::HALF_BITS-1:0]     hp;
  logic [sdac_pkg::GEN_WORD_BITS-1:0] next_word;
  logic [sdac_pkg::COUNT_BITS-1:0]    bc_inc;
  logic [sdac_pkg::COUNT_BITS-1:0]    nbits;
  logic                               valid_bit;
  logic                               rej_bit;
  logic                               cfg_write;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= sdac_pkg::HALF_RESET;
    end else if (cfg_write && paddr == sdac_pkg::REG_HALF_PERIOD) begin
      half_period_ticks <= pwdata[sdac_pkg::HALF_BITS-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr == sdac_pkg::REG_HALF_PERIOD) begin
      prdata = {{(32-sdac_pkg::HALF_BITS){1'b0}}, half_period_ticks};
    end
  end

  // stream handshake
  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  assign in_op      = s_axis_tuser;
  assign in_freq    = s_axis_tdata[27:0];
  assign in_channel = s_axis_tdata[28];
  assign in_miso    = s_axis_tdata[29];

  // zero half period acts as one
  assign hp        = (half_period_ticks == '0) ? 8'd1 : half_period_ticks;
  assign next_word = sdac_pkg::gen_word(word_index, held_freq);
  assign bc_inc    = bit_count + 5'd1;

  // bits in the current word
  always_comb begin
    case (phase)
      PH_GEN:  nbits = 5'(sdac_pkg::GEN_WORD_BITS);
      PH_CMD:  nbits = 5'(sdac_pkg::CMD_BITS);
      default: nbits = 5'(sdac_pkg::ADC_BITS);
    endcase
  end

  // sequencer step for one accepted word
  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    word_index_next   = word_index;
    shift_out_next    = shift_out;
    shift_in_next     = shift_in;
    divider_next      = divider;
    held_freq_next    = held_freq;
    held_channel_next = held_channel;
    sclk_next         = sclk;
    mosi_next         = mosi;
    gen_sel_n_next    = gen_sel_n;
    adc_sel_n_next    = adc_sel_n;
    last_sample_next  = last_sample;
    valid_bit         = 1'b0;
    rej_bit           = 1'b0;

    if (accept) begin
      case (in_op)
        sdac_pkg::OP_FREQ, sdac_pkg::OP_READ: begin
          if (phase != PH_IDLE) begin
            rej_bit = 1'b1;
          end else if (in_op == sdac_pkg::OP_FREQ) begin
            held_freq_next  = in_freq;
            word_index_next = 2'd0;
            divider_next    = '0;
            shift_out_next  = sdac_pkg::GEN_CTRL_WORD;
            gen_sel_n_next  = 1'b0;
            sclk_next       = 1'b0;
            bit_count_next  = '0;
            mosi_next       = sdac_pkg::GEN_CTRL_WORD[sdac_pkg::GEN_WORD_BITS-1];
            phase_next      = PH_GEN;
          end else begin
            held_channel_next = in_channel;
            shift_out_next    = {12'd0, sdac_pkg::ADC_CMD_BASE | {2'b00, in_channel, 1'b0}};
            adc_sel_n_next    = 1'b0;
            sclk_next         = 1'b0;
            bit_count_next    = '0;
            divider_next      = '0;
            mosi_next         = sdac_pkg::ADC_CMD_BASE[sdac_pkg::CMD_BITS-1];
            phase_next        = PH_CMD;
          end
        end
        sdac_pkg::OP_TICK: begin
          if (phase != PH_IDLE) begin
            if ({1'b0, divider} + 9'd1 < {1'b0, hp}) begin
              divider_next = divider + 8'd1;
            end else begin
              divider_next = '0;
              if (phase == PH_GAP) begin
                // start the next generator word
                shift_out_next = next_word;
                gen_sel_n_next = 1'b0;
                sclk_next      = 1'b0;
                bit_count_next = '0;
                mosi_next      = next_word[sdac_pkg::GEN_WORD_BITS-1];
                phase_next     = PH_GEN;
              end else if (!sclk) begin
                // rising edge, sample during data bits
                sclk_next = 1'b1;
                if (phase == PH_DATA) begin
                  shift_in_next = {shift_in[sdac_pkg::ADC_BITS-2:0], in_miso};
                end
              end else begin
                // falling edge, move to next bit
                sclk_next      = 1'b0;
                bit_count_next = bc_inc;
                if (bc_inc < nbits) begin
                  if (phase == PH_GEN) begin
                    mosi_next = shift_out[4'(5'(sdac_pkg::GEN_WORD_BITS - 1) - bc_inc)];
                  end else if (phase == PH_CMD) begin
                    mosi_next = shift_out[2'(5'(sdac_pkg::CMD_BITS - 1) - bc_inc)];
                  end
                end else begin
                  case (phase)
                    PH_GEN: begin
                      gen_sel_n_next  = 1'b1;
                      word_index_next = word_index + 2'd1;
                      phase_next      = (word_index == 2'd2) ? PH_IDLE : PH_GAP;
                    end
                    PH_CMD: begin
                      phase_next     = PH_DATA;
                      bit_count_next = '0;
                      shift_in_next  = '0;
                    end
                    default: begin
                      adc_sel_n_next   = 1'b1;
                      last_sample_next = shift_in;
                      phase_next       = PH_IDLE;
                      valid_bit        = 1'b1;
                    end
                  endcase
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      word_index   <= '0;
      shift_out    <= '0;
      shift_in     <= '0;
      divider      <= '0;
      held_freq    <= '0;
      held_channel <= 1'b0;
      sclk         <= 1'b0;
      mosi         <= 1'b0;
      gen_sel_n    <= 1'b1;
      adc_sel_n    <= 1'b1;
      last_sample  <= '0;
    end else begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      word_index   <= word_index_next;
      shift_out    <= shift_out_next;
      shift_in     <= shift_in_next;
      divider      <= divider_next;
      held_freq    <= held_freq_next;
      held_channel <= held_channel_next;
      sclk         <= sclk_next;
      mosi         <= mosi_next;
      gen_sel_n    <= gen_sel_n_next;
      adc_sel_n    <= adc_sel_n_next;
      last_sample  <= last_sample_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {5'd0, rej_bit, (phase_next != PH_IDLE), valid_bit,
                       last_sample_next, adc_sel_n_next, gen_sel_n_next,
                       mosi_next, sclk_next};
    end
  end

endmodule

`default_nettype wire

>>> verif/spi_dds_adc_controller_test.sv
`default_nettype none

module spi_dds_adc_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  // no-op selector value
  localparam logic [sdac_pkg::OP_BITS-1:0] OP_NONE = 2'd3;

  // line levels and status carried by one result word
  typedef struct packed {
    logic                          sclk;
    logic                          mosi;
    logic                          gen_n;
    logic                          adc_n;
    logic [sdac_pkg::ADC_BITS-1:0] sample;
    logic                          valid;
    logic                          busy;
    logic                          rej;
  } lines_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_GEN,
    SEQ_GAP,
    SEQ_CMD,
    SEQ_DATA
  } seq_t;

  typedef struct packed {
    logic [sdac_pkg::OP_BITS-1:0]   op;
    logic [sdac_pkg::FREQ_BITS-1:0] freq;
    logic                           ch;
    logic                           miso;
    logic                           typed;
    lines_t                         lines;
  } stim_row_t;

  localparam lines_t NO_LINES     = '0;
  localparam lines_t IDLE_LINES   = '{1'b0, 1'b0, 1'b1, 1'b1, 12'd0, 1'b0, 1'b0, 1'b0};
  localparam lines_t READ_CH1     = '{1'b0, 1'b1, 1'b1, 1'b0, 12'd0, 1'b0, 1'b1, 1'b0};
  localparam lines_t READ_CH1_REJ = '{1'b0, 1'b1, 1'b1, 1'b0, 12'd0, 1'b0, 1'b1, 1'b1};
  localparam logic [sdac_pkg::FREQ_BITS-1:0] FREQ_MAX = 28'hFFF_FFFF;

  // directed words: reset levels, no-op, read start, starts while busy, divider
  localparam stim_row_t DIRECTED_ROWS [0:16] = '{
    '{sdac_pkg::OP_TICK, 28'd0,       1'b0, 1'b0, 1'b1, IDLE_LINES},
    '{OP_NONE,           FREQ_MAX,    1'b1, 1'b1, 1'b1, IDLE_LINES},
    '{sdac_pkg::OP_TICK, FREQ_MAX,    1'b1, 1'b1, 1'b1, IDLE_LINES},
    '{sdac_pkg::OP_READ, 28'd0,       1'b1, 1'b0, 1'b1, READ_CH1},
    '{sdac_pkg::OP_FREQ, FREQ_MAX,    1'b0, 1'b0, 1'b1, READ_CH1_REJ},
    '{sdac_pkg::OP_READ, 28'd0,       1'b0, 1'b1, 1'b1, READ_CH1_REJ},
    '{OP_NONE,           28'd0,       1'b0, 1'b0, 1'b1, READ_CH1},
    '{sdac_pkg::OP_TICK, 28'd0,       1'b0, 1'b1, 1'b1, READ_CH1},
    '{sdac_pkg::OP_TICK, 28'd0,       1'b0, 1'b1, 1'b1, READ_CH1},
    '{sdac_pkg::OP_TICK, 28'd0,       1'b0, 1'b1, 1'b1, READ_CH1},
    '{sdac_pkg::OP_TICK, 28'd0,       1'b0, 1'b1, 1'b1, READ_CH1},
    '{sdac_pkg::OP_TICK, 28'd0,       1'b0, 1'b0, 1'b0, NO_LINES},
    '{sdac_pkg::OP_TICK, 28'h5A5A5A5, 1'b1, 1'b1, 1'b0, NO_LINES},
    '{sdac_pkg::OP_TICK, 28'd0,       1'b0, 1'b1, 1'b0, NO_LINES},
    '{sdac_pkg::OP_TICK, 28'd0,       1'b0, 1'b0, 1'b0, NO_LINES},
    '{sdac_pkg::OP_FREQ, 28'd0,       1'b0, 1'b0, 1'b0, NO_LINES},
    '{sdac_pkg::OP_TICK, 28'd0,       1'b1, 1'b1, 1'b0, NO_LINES}
  };

  localparam logic [sdac_pkg::HALF_BITS-1:0] HALF_SETTINGS [0:4] =
    '{8'd1, 8'd0, 8'd255, 8'd3, 8'd2};
  localparam int HALF_BUDGETS [0:4] = '{150, 150, 300, 100, 100};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = sdac_pkg::REG_HALF_PERIOD;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tune_word[27:0], channel[28], miso[29], zero fill[31:30]
  logic [31:0] s_axis_tdata = '0;
  // op[1:0]
  logic [1:0]  s_axis_tuser = sdac_pkg::OP_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // sclk[0], mosi[1], gen_select_n[2], adc_select_n[3], sample[15:4],
  // sample_valid[16], busy_res[17], rejected[18], zero fill[23:19]
  logic [23:0] m_axis_tdata;

  spi_dds_adc_controller u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // serial master mirror state
  seq_t                               seq = SEQ_IDLE;
  int                                 bit_cnt = 0;
  logic [1:0]                         word_idx = '0;
  logic [sdac_pkg::GEN_WORD_BITS-1:0] out_sr = '0;
  logic [sdac_pkg::ADC_BITS-1:0]      in_sr = '0;
  int                                 div_cnt = 0;
  logic [sdac_pkg::FREQ_BITS-1:0]     freq_hold = '0;
  logic                               chan_hold = 1'b0;
  logic                               sclk_q = 1'b0;
  logic                               mosi_q = 1'b0;
  logic                               gen_n_q = 1'b1;
  logic                               adc_n_q = 1'b1;
  logic [sdac_pkg::ADC_BITS-1:0]      sample_q = '0;
  logic [sdac_pkg::HALF_BITS-1:0]     half_reg = sdac_pkg::HALF_RESET;

  lines_t expected_lines [$];
  int     fail_count = 0;
  int     words_checked = 0;
  int     words_sent = 0;
  int     loads_started = 0;
  int     reads_started = 0;
  int     samples_done = 0;
  int     starts_rejected = 0;
  int     burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // load the next generator word and drive its first bit
  function automatic void load_gen_word();
    case (word_idx)
      2'd0:    out_sr = sdac_pkg::GEN_CTRL_WORD;
      2'd1:    out_sr = {2'b00, freq_hold[sdac_pkg::FREQ_HALF-1:0]} | sdac_pkg::GEN_FREQ_FLAG;
      default: out_sr = {2'b00, freq_hold[sdac_pkg::FREQ_BITS-1:sdac_pkg::FREQ_HALF]} |
                        sdac_pkg::GEN_FREQ_FLAG;
    endcase
    gen_n_q = 1'b0;
    sclk_q  = 1'b0;
    bit_cnt = 0;
    mosi_q  = out_sr[sdac_pkg::GEN_WORD_BITS-1];
    seq     = SEQ_GEN;
  endfunction

  // one half period boundary of the serial clock; returns 1 when a read completes
  function automatic bit serial_half_edge(input logic miso);
    int nbits;
    if (seq == SEQ_GAP) begin
      load_gen_word();
      return 1'b0;
    end
    if (!sclk_q) begin
      sclk_q = 1'b1;
      if (seq == SEQ_DATA) in_sr = {in_sr[sdac_pkg::ADC_BITS-2:0], miso};
      return 1'b0;
    end
    sclk_q = 1'b0;
    bit_cnt++;
    nbits = (seq == SEQ_GEN) ? sdac_pkg::GEN_WORD_BITS :
            (seq == SEQ_CMD) ? sdac_pkg::CMD_BITS : sdac_pkg::ADC_BITS;
    if (bit_cnt < nbits) begin
      if (seq != SEQ_DATA) mosi_q = out_sr[nbits-1-bit_cnt];
      return 1'b0;
    end
    case (seq)
      SEQ_GEN: begin
        gen_n_q = 1'b1;
        word_idx++;
        seq = (word_idx < 2'd3) ? SEQ_GAP : SEQ_IDLE;
      end
      SEQ_CMD: begin
        seq     = SEQ_DATA;
        bit_cnt = 0;
        in_sr   = '0;
      end
      default: begin
        adc_n_q  = 1'b1;
        sample_q = in_sr;
        seq      = SEQ_IDLE;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // advance the mirror by one accepted word and return the line levels it leaves
  function automatic lines_t predict_lines(input logic [sdac_pkg::OP_BITS-1:0] op,
                                           input logic [sdac_pkg::FREQ_BITS-1:0] freq,
                                           input logic ch, input logic miso);
    lines_t r;
    int     hp;
    r  = '0;
    hp = (half_reg == '0) ? 1 : int'(half_reg);
    if (op == sdac_pkg::OP_FREQ || op == sdac_pkg::OP_READ) begin
      if (seq != SEQ_IDLE) begin
        r.rej = 1'b1;
        starts_rejected++;
      end else if (op == sdac_pkg::OP_FREQ) begin
        freq_hold = freq;
        word_idx  = '0;
        div_cnt   = 0;
        load_gen_word();
        loads_started++;
      end else begin
        chan_hold = ch;
        out_sr    = {12'd0, sdac_pkg::ADC_CMD_BASE | {2'b00, chan_hold, 1'b0}};
        adc_n_q   = 1'b0;
        sclk_q    = 1'b0;
        bit_cnt   = 0;
        div_cnt   = 0;
        mosi_q    = out_sr[sdac_pkg::CMD_BITS-1];
        seq       = SEQ_CMD;
        reads_started++;
      end
    end else if (op == sdac_pkg::OP_TICK && seq != SEQ_IDLE) begin
      if (div_cnt + 1 < hp) begin
        div_cnt++;
      end else begin
        div_cnt = 0;
        r.valid = serial_half_edge(miso);
        if (r.valid) samples_done++;
      end
    end
    r.sclk   = sclk_q;
    r.mosi   = mosi_q;
    r.gen_n  = gen_n_q;
    r.adc_n  = adc_n_q;
    r.sample = sample_q;
    r.busy   = (seq != SEQ_IDLE);
    return r;
  endfunction

  // offer one word in bursts with random gaps, then record what it should produce
  task automatic offer_word(input logic [sdac_pkg::OP_BITS-1:0] op,
                            input logic [sdac_pkg::FREQ_BITS-1:0] freq,
                            input logic ch, input logic miso,
                            input logic typed, input lines_t typed_lines);
    lines_t predicted;
    int     gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, miso, ch, freq};
    s_axis_tuser  = op;
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_lines(op, freq, ch, miso);
    expected_lines.push_back(typed ? typed_lines : predicted);
    words_sent++;
  endtask

  // well-formed start sequences with random content, plus stray starts and no-ops
  task automatic run_random(input int budget, input bit reads_only);
    int                             count;
    int                             pick;
    logic [sdac_pkg::OP_BITS-1:0]   op;
    logic [sdac_pkg::FREQ_BITS-1:0] freq;
    count = 0;
    while (count < budget) begin
      pick = $urandom_range(0, 19);
      case ($urandom_range(0, 7))
        0:       freq = '0;
        1:       freq = FREQ_MAX;
        default: freq = sdac_pkg::FREQ_BITS'($urandom());
      endcase
      if (seq == SEQ_IDLE) begin
        if (reads_only) op = sdac_pkg::OP_READ;
        else op = (pick < 8) ? sdac_pkg::OP_FREQ : (pick < 16) ? sdac_pkg::OP_READ :
                  (pick < 18) ? sdac_pkg::OP_TICK : OP_NONE;
      end else begin
        op = (pick == 0) ? sdac_pkg::OP_FREQ : (pick == 1) ? sdac_pkg::OP_READ :
             (pick == 2) ? OP_NONE : sdac_pkg::OP_TICK;
      end
      offer_word(op, freq, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, NO_LINES);
      count++;
    end
  endtask

  // stop offering and wait for every outstanding result word
  task automatic wait_for_drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
  endtask

  // apb write of the half period register: setup then access
  task automatic write_half_period(input logic [sdac_pkg::HALF_BITS-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = sdac_pkg::REG_HALF_PERIOD;
    pwdata  = {24'd0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    half_reg = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    lines_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_lines.size() == 0) begin
        $error("result word with nothing expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_lines.pop_front();
        check_field("sclk", want.sclk, m_axis_tdata[0]);
        check_field("mosi", want.mosi, m_axis_tdata[1]);
        check_field("gen_select_n", want.gen_n, m_axis_tdata[2]);
        check_field("adc_select_n", want.adc_n, m_axis_tdata[3]);
        check_field("sample", want.sample, m_axis_tdata[15:4]);
        check_field("sample_valid", want.valid, m_axis_tdata[16]);
        check_field("busy_res", want.busy, m_axis_tdata[17]);
        check_field("rejected", want.rej, m_axis_tdata[18]);
        words_checked++;
      end
    end
  end

  // result side: changing stall modes, plus one long hold-off
  initial begin
    int  cyc;
    int  mode;
    int  hold_cycles;
    bit  long_hold_done;
    cyc            = 0;
    mode           = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && words_checked >= 400) begin
        long_hold_done = 1'b1;
        m_axis_tready  = 1'b0;
        hold_cycles    = 0;
        while (hold_cycles < 300) begin
          @(negedge clk);
          hold_cycles++;
        end
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      cyc++;
      case (mode)
        0:       m_axis_tready = 1'b1;
        1:       m_axis_tready = ($urandom_range(0, 9) >= 3);
        default: m_axis_tready = (cyc % 3 == 0);
      endcase
    end
  end

  // reset, directed table, then random phases under several half period settings
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (DIRECTED_ROWS[i]) begin
      offer_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].freq, DIRECTED_ROWS[i].ch,
                 DIRECTED_ROWS[i].miso, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].lines);
    end
    run_random(200, 1'b0);
    foreach (HALF_SETTINGS[k]) begin
      wait_for_drain();
      write_half_period(HALF_SETTINGS[k]);
      run_random(HALF_BUDGETS[k], HALF_SETTINGS[k] == 8'd255);
    end
    wait_for_drain();
    repeat (8) @(posedge clk);
    $display("sent %0d words: %0d frequency loads, %0d converter reads, %0d samples, %0d rejected",
             words_sent, loads_started, reads_started, samples_done, starts_rejected);
    $display("checked %0d result words over half periods 5, 1, 0, 255, 3, 2",
             words_checked);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
